@@ src/rvdq_pkg.sv @@
// Shared constants, types and ring arithmetic for the reversible deque.
`default_nettype none

package rvdq_pkg;

    // Ring store depth and the widths that follow from it.
    localparam int DEPTH = 1024;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    localparam int DATA_W   = 16;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_TOGGLE = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_TAKE   = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ERROR      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY_TAKE = 2'd3;

    // Result flags that travel alongside the memory read.
    typedef struct packed {
        logic                data_valid;
        logic                last;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // Ring addition of two in-range indexes: one add and one conditional subtract.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] offset);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/reversible_deque_core.sv @@
// Top level of the reversible deque: control, ring store and result pipeline.
// Results pass through the pending stage and the output register. Throughput: one item
// per cycle when not stalled by m_ready; the single ring store port serves one append
// write or one take read per item, and all pointer updates finish in the accept cycle.
// Reset: synchronous, active low; empties the deque and clears the reverse and error
// flags. The ring store has no reset, since only entries appended since a clear are read.
`default_nettype none

module reversible_deque_core import rvdq_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [OP_W-1:0]     s_operation,
    input  wire logic [DATA_W-1:0]   s_value,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [DATA_W-1:0]   m_data_out,
    output logic                     m_data_valid,
    output logic                     m_last,
    output logic      [STATUS_W-1:0] m_status
);

    // The control block updates every pointer and flag in the cycle an item is
    // accepted and issues at most one ring store access. The read data of a take
    // arrives in the next cycle, so results pass through a pending stage (waiting on
    // the RAM) and then an output register. The RAM only updates its read data on
    // a read, so a stalled pending stage keeps its data stable.

    logic                accept;
    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_addr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;
    rsp_t                rsp;

    logic                pend_valid_reg, pend_valid_next;
    rsp_t                pend_rsp_reg, pend_rsp_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_rsp_reg, out_rsp_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic                advance;

    // The pending stage moves forward whenever the output register is free or
    // being emptied; a new item enters whenever the pending stage will be free.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !pend_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    rvdq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .operation (s_operation),
        .value     (s_value),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .rsp       (rsp)
    );

    rvdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_rsp_next   = pend_rsp_reg;
        out_valid_next  = out_valid_reg;
        out_rsp_next    = out_rsp_reg;
        out_data_next   = out_data_reg;

        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (pend_valid_reg && advance) begin
            out_valid_next  = 1'b1;
            out_rsp_next    = pend_rsp_reg;
            // Only a successful take returns store data; every other item shows zero.
            out_data_next   = pend_rsp_reg.data_valid ? ram_rdata : '0;
            pend_valid_next = 1'b0;
        end
        if (accept) begin
            pend_valid_next = 1'b1;
            pend_rsp_next   = rsp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_rsp_reg <= pend_rsp_next;
        out_rsp_reg  <= out_rsp_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_data_out   = out_data_reg;
    assign m_data_valid = out_rsp_reg.data_valid;
    assign m_last       = out_rsp_reg.last;
    assign m_status     = out_rsp_reg.status;

endmodule

`default_nettype wire

@@ src/rvdq_ram.sv @@
// Generic single-port RAM with a registered read port.
`default_nettype none

module rvdq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                      wdata,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            ram_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= ram_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/rvdq_ctrl.sv @@
// Deque pointer state, operation decode and ring store address generation.
`default_nettype none

module rvdq_ctrl import rvdq_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic [DATA_W-1:0]   value,
    output logic                     ram_we,
    output logic                     ram_re,
    output logic      [AW-1:0]       ram_addr,
    output logic      [DATA_W-1:0]   ram_wdata,
    output rsp_t                     rsp
);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;
    logic          err_reg, err_next;

    logic [AW-1:0] tail_addr;
    logic [AW-1:0] back_addr;
    logic [AW-1:0] front_inc;
    logic [CW-1:0] count_dec;

    assign count_dec = count_reg - CW'(1);
    assign tail_addr = ring_add(front_reg, count_reg[AW-1:0]);
    assign back_addr = ring_add(front_reg, count_dec[AW-1:0]);
    assign front_inc = ring_add(front_reg, AW'(1));
    assign ram_wdata = value;

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        err_next   = err_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = front_reg;
        rsp        = '{data_valid: 1'b0, last: 1'b0, status: ST_OK};

        if (accept) begin
            if (operation == OP_CLEAR) begin
                front_next = '0;
                count_next = '0;
                rev_next   = 1'b0;
                err_next   = 1'b0;
            end else if (err_reg) begin
                rsp.status = ST_ERROR;
            end else begin
                case (operation)
                    OP_APPEND: begin
                        if (count_reg >= CW'(DEPTH)) begin
                            rsp.status = ST_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_addr   = tail_addr;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_TOGGLE: begin
                        rev_next = ~rev_reg;
                    end
                    OP_DELETE, OP_TAKE: begin
                        if (count_reg == '0) begin
                            if (operation == OP_DELETE) begin
                                err_next   = 1'b1;
                                rsp.status = ST_ERROR;
                            end else begin
                                rsp.status = ST_EMPTY_TAKE;
                            end
                        end else begin
                            count_next = count_dec;
                            if (!rev_reg) begin
                                front_next = front_inc;
                                ram_addr   = front_reg;
                            end else begin
                                ram_addr = back_addr;
                            end
                            if (operation == OP_TAKE) begin
                                ram_re         = 1'b1;
                                rsp.data_valid = 1'b1;
                                rsp.last       = (count_dec == '0);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire
